@@ rtl/rau_pkg.sv @@
// Shared constants, codes and control types of the rational arithmetic unit.
package rau_pkg;

   localparam int WORD_BITS  = 32;
   localparam int WIDE_BITS  = 2 * WORD_BITS;
   localparam int CNT_BITS   = $clog2(WIDE_BITS);
   localparam int SHIFT_BITS = CNT_BITS + 1;

   localparam logic [1:0] CMD_ADD = 2'd0;
   localparam logic [1:0] CMD_SUB = 2'd1;
   localparam logic [1:0] CMD_MUL = 2'd2;
   localparam logic [1:0] CMD_DIV = 2'd3;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
   localparam logic [1:0] STATUS_INVALID  = 2'd2;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_GCD_DEN,
      OP_GCD_RES,
      OP_GCD_STEP,
      OP_DIV_QB,
      OP_DIV_QA,
      OP_DIV_NM,
      OP_DIV_DN,
      OP_DIV_STEP,
      OP_SAVE_QB,
      OP_SAVE_QA,
      OP_SAVE_NM,
      OP_SAVE_DN,
      OP_MUL_TA,
      OP_MUL_TB,
      OP_MUL_DA,
      OP_PROD_NUM,
      OP_PROD_DEN,
      OP_COMBINE,
      OP_FINISH,
      OP_FAIL
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic invalid;
      logic add_sub;
      logic gcd_done;
   } dp_stat_type;

endpackage

@@ rtl/rational_arithmetic_unit.sv @@
// Top level of the rational arithmetic unit: unpacks requests, joins controller and datapath.
//
// The unit takes one request on the req_ stream: a command (add, subtract, multiply,
// divide) and two fractions, each a signed numerator over an unsigned denominator.
// It returns one response on the rsp_ stream: the result reduced to lowest terms with
// a status code (ok, overflow, or zero divisor / zero denominator).
// One request is processed at a time. The binary gcd unit takes one step per cycle
// over the 64-bit intermediates, and each of the divisions by the gcd runs in the
// bit-serial restoring divider. An invalid request passes from the check state to the
// fail state, and its response is presented once the output register is free.
// The response sits in an output register; the next request is accepted while it
// waits, but a finished result is held back until rsp_tready frees that register.
// Synchronous reset returns the controller to idle and drops any pending response.
module rational_arithmetic_unit (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // cmd[1:0], a_num[33:2], a_den[65:34], b_num[97:66], b_den[129:98], zero[135:130]
   input  logic [135:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // res_num[31:0], res_den[63:32], status[65:64], zero[71:66]
   output logic [71:0]   rsp_tdata
);

   rau_pkg::dp_cmd_type  ctl;
   rau_pkg::dp_stat_type stat;
   logic [31:0] res_num, res_den;
   logic [1:0]  status;

   rau_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .ctl        (ctl)
   );

   rau_dp u_dp (
      .clock   (clock),
      .cmd     (req_tdata[1:0]),
      .a_num   (req_tdata[33:2]),
      .a_den   (req_tdata[65:34]),
      .b_num   (req_tdata[97:66]),
      .b_den   (req_tdata[129:98]),
      .ctl     (ctl),
      .stat    (stat),
      .res_num (res_num),
      .res_den (res_den),
      .status  (status)
   );

   assign rsp_tdata = {6'b0, status, res_den, res_num};

endmodule

@@ rtl/rau_dp.sv @@
// Datapath: operand registers, shared multiplier, binary gcd unit and restoring divider.
module rau_dp (
   input  logic                   clock,
   input  logic [1:0]             cmd,
   input  logic [31:0]            a_num,
   input  logic [31:0]            a_den,
   input  logic [31:0]            b_num,
   input  logic [31:0]            b_den,
   input  rau_pkg::dp_cmd_type    ctl,
   output rau_pkg::dp_stat_type   stat,
   output logic [31:0]            res_num,
   output logic [31:0]            res_den,
   output logic [1:0]             status
);

   localparam int W = rau_pkg::WORD_BITS;
   localparam int X = rau_pkg::WIDE_BITS;
   localparam logic [X-1:0] TOP = {{W{1'b0}}, 1'b1, {(W-1){1'b0}}};

   logic [1:0]   cmd_ff;
   logic [W-1:0] am_ff, ad_ff, bm_ff, bd_ff;
   logic         an_ff, bn_ff, sg_ff;
   logic [X-1:0] nm_ff, dn_ff, t0_ff, t1_ff;
   logic [X-1:0] gx_ff, gy_ff, dq_ff, dd_ff;
   logic [X:0]   dr_ff;
   logic [rau_pkg::SHIFT_BITS-1:0] gk_ff;
   logic [31:0]  num_out_ff, den_out_ff;
   logic [1:0]   status_ff;

   logic [W-1:0] a_word, b_word, a_mag, b_mag;
   logic [X-1:0] gres;
   logic [X-1:0] gx_in, gy_in;
   logic [rau_pkg::SHIFT_BITS-1:0] gk_in;
   logic [X:0]   rs, diff;
   logic         ge;
   logic [W-1:0] mul_x, mul_y;
   logic [X-1:0] prod;
   logic         is_div, tbn, rn, ovf;
   logic [X-1:0] sum_nm;
   logic         sum_sg;
   logic [W-1:0] num_w;

   assign a_word = a_num[W-1:0];
   assign b_word = b_num[W-1:0];
   assign a_mag  = a_word[W-1] ? (~a_word + 1'b1) : a_word;
   assign b_mag  = b_word[W-1] ? (~b_word + 1'b1) : b_word;
   assign is_div = (cmd_ff == rau_pkg::CMD_DIV);

   assign gres = (gx_ff | gy_ff) << gk_ff;

   always_comb begin
      gx_in = gx_ff;
      gy_in = gy_ff;
      gk_in = gk_ff;
      if (gx_ff != '0 && gy_ff != '0) begin
         if (!gx_ff[0] && !gy_ff[0]) begin
            gx_in = gx_ff >> 1;
            gy_in = gy_ff >> 1;
            gk_in = gk_ff + 1'b1;
         end else if (!gx_ff[0]) begin
            gx_in = gx_ff >> 1;
         end else if (!gy_ff[0]) begin
            gy_in = gy_ff >> 1;
         end else if (gx_ff >= gy_ff) begin
            gx_in = (gx_ff - gy_ff) >> 1;
         end else begin
            gy_in = (gy_ff - gx_ff) >> 1;
         end
      end
   end

   assign rs   = {dr_ff[X-1:0], dq_ff[X-1]};
   assign ge   = (rs >= {1'b0, dd_ff});
   assign diff = rs - {1'b0, dd_ff};

   always_comb begin
      case (ctl.op)
         rau_pkg::OP_MUL_TA: begin
            mul_x = am_ff;
            mul_y = t0_ff[W-1:0];
         end
         rau_pkg::OP_MUL_TB: begin
            mul_x = bm_ff;
            mul_y = t1_ff[W-1:0];
         end
         rau_pkg::OP_MUL_DA: begin
            mul_x = t1_ff[W-1:0];
            mul_y = bd_ff;
         end
         rau_pkg::OP_PROD_NUM: begin
            mul_x = am_ff;
            mul_y = is_div ? bd_ff : bm_ff;
         end
         rau_pkg::OP_PROD_DEN: begin
            mul_x = ad_ff;
            mul_y = is_div ? bm_ff : bd_ff;
         end
         default: begin
            mul_x = am_ff;
            mul_y = bm_ff;
         end
      endcase
   end

   assign prod = {{W{1'b0}}, mul_x} * {{W{1'b0}}, mul_y};

   always_comb begin
      tbn = (cmd_ff == rau_pkg::CMD_SUB) ? !bn_ff : bn_ff;
      if (t0_ff == '0) begin
         tbn = 1'b0;
      end
      if (an_ff == tbn) begin
         sum_nm = nm_ff + t0_ff;
         sum_sg = an_ff;
      end else if (nm_ff >= t0_ff) begin
         sum_nm = nm_ff - t0_ff;
         sum_sg = an_ff;
      end else begin
         sum_nm = t0_ff - nm_ff;
         sum_sg = tbn;
      end
   end

   assign rn    = sg_ff && (nm_ff != '0);
   assign ovf   = (dn_ff[X-1:W] != '0) || (rn ? (nm_ff > TOP) : (nm_ff > TOP - 1'b1));
   assign num_w = rn ? (~nm_ff[W-1:0] + 1'b1) : nm_ff[W-1:0];

   always_ff @(posedge clock) begin
      case (ctl.op)
         rau_pkg::OP_LOAD: begin
            cmd_ff <= cmd;
            am_ff  <= a_mag;
            an_ff  <= a_word[W-1];
            ad_ff  <= a_den[W-1:0];
            bm_ff  <= b_mag;
            bn_ff  <= b_word[W-1];
            bd_ff  <= b_den[W-1:0];
         end
         rau_pkg::OP_GCD_DEN: begin
            gx_ff <= {{W{1'b0}}, ad_ff};
            gy_ff <= {{W{1'b0}}, bd_ff};
            gk_ff <= '0;
         end
         rau_pkg::OP_GCD_RES: begin
            gx_ff <= nm_ff;
            gy_ff <= dn_ff;
            gk_ff <= '0;
         end
         rau_pkg::OP_GCD_STEP: begin
            gx_ff <= gx_in;
            gy_ff <= gy_in;
            gk_ff <= gk_in;
         end
         rau_pkg::OP_DIV_QB: begin
            dq_ff <= {{W{1'b0}}, bd_ff};
            dr_ff <= '0;
            dd_ff <= gres;
         end
         rau_pkg::OP_DIV_QA: begin
            dq_ff <= {{W{1'b0}}, ad_ff};
            dr_ff <= '0;
            dd_ff <= gres;
         end
         rau_pkg::OP_DIV_NM: begin
            dq_ff <= nm_ff;
            dr_ff <= '0;
            dd_ff <= gres;
         end
         rau_pkg::OP_DIV_DN: begin
            dq_ff <= dn_ff;
            dr_ff <= '0;
            dd_ff <= gres;
         end
         rau_pkg::OP_DIV_STEP: begin
            dr_ff <= ge ? diff : rs;
            dq_ff <= {dq_ff[X-2:0], ge};
         end
         rau_pkg::OP_SAVE_QB: t0_ff <= dq_ff;
         rau_pkg::OP_SAVE_QA: t1_ff <= dq_ff;
         rau_pkg::OP_SAVE_NM: nm_ff <= dq_ff;
         rau_pkg::OP_SAVE_DN: dn_ff <= dq_ff;
         rau_pkg::OP_MUL_TA:  nm_ff <= prod;
         rau_pkg::OP_MUL_TB:  t0_ff <= prod;
         rau_pkg::OP_MUL_DA:  dn_ff <= prod;
         rau_pkg::OP_PROD_NUM: begin
            nm_ff <= prod;
            sg_ff <= an_ff ^ bn_ff;
         end
         rau_pkg::OP_PROD_DEN: dn_ff <= prod;
         rau_pkg::OP_COMBINE: begin
            nm_ff <= sum_nm;
            sg_ff <= sum_sg;
         end
         rau_pkg::OP_FINISH: begin
            if (ovf) begin
               num_out_ff <= '0;
               den_out_ff <= '0;
               status_ff  <= rau_pkg::STATUS_OVERFLOW;
            end else begin
               num_out_ff <= 32'(signed'(num_w));
               den_out_ff <= 32'(dn_ff[W-1:0]);
               status_ff  <= rau_pkg::STATUS_OK;
            end
         end
         rau_pkg::OP_FAIL: begin
            num_out_ff <= '0;
            den_out_ff <= '0;
            status_ff  <= rau_pkg::STATUS_INVALID;
         end
         default: begin
         end
      endcase
   end

   assign stat.invalid  = (ad_ff == '0) || (bd_ff == '0) || (is_div && bm_ff == '0);
   assign stat.add_sub  = (cmd_ff == rau_pkg::CMD_ADD) || (cmd_ff == rau_pkg::CMD_SUB);
   assign stat.gcd_done = (gx_ff == '0) || (gy_ff == '0);

   assign res_num = num_out_ff;
   assign res_den = den_out_ff;
   assign status  = status_ff;

endmodule

@@ rtl/rau_ctrl.sv @@
// Controller: sequences the datapath operations and runs the request and response handshakes.
module rau_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  rau_pkg::dp_stat_type  stat,
   output rau_pkg::dp_cmd_type   ctl
);

   typedef enum logic [4:0] {
      ST_IDLE, ST_CHECK, ST_GD, ST_GRUN, ST_DQB, ST_DRUN, ST_SQB, ST_DQA, ST_SQA,
      ST_MTA, ST_MTB, ST_MDA, ST_COMB, ST_PN, ST_PD, ST_GR, ST_DNM, ST_SNM,
      ST_DDN, ST_SDN, ST_FIN, ST_FAIL
   } state_type;

   state_type state_ff, ret_ff;
   logic [rau_pkg::CNT_BITS-1:0] cnt_ff;
   logic rsp_valid_ff;
   logic out_free;

   localparam logic [rau_pkg::CNT_BITS-1:0] CNT_LAST =
      rau_pkg::CNT_BITS'(rau_pkg::WIDE_BITS - 1);

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      case (state_ff)
         ST_IDLE: ctl.op = req_tvalid ? rau_pkg::OP_LOAD : rau_pkg::OP_NONE;
         ST_GD:   ctl.op = rau_pkg::OP_GCD_DEN;
         ST_GRUN: ctl.op = rau_pkg::OP_GCD_STEP;
         ST_DQB:  ctl.op = rau_pkg::OP_DIV_QB;
         ST_DRUN: ctl.op = rau_pkg::OP_DIV_STEP;
         ST_SQB:  ctl.op = rau_pkg::OP_SAVE_QB;
         ST_DQA:  ctl.op = rau_pkg::OP_DIV_QA;
         ST_SQA:  ctl.op = rau_pkg::OP_SAVE_QA;
         ST_MTA:  ctl.op = rau_pkg::OP_MUL_TA;
         ST_MTB:  ctl.op = rau_pkg::OP_MUL_TB;
         ST_MDA:  ctl.op = rau_pkg::OP_MUL_DA;
         ST_COMB: ctl.op = rau_pkg::OP_COMBINE;
         ST_PN:   ctl.op = rau_pkg::OP_PROD_NUM;
         ST_PD:   ctl.op = rau_pkg::OP_PROD_DEN;
         ST_GR:   ctl.op = rau_pkg::OP_GCD_RES;
         ST_DNM:  ctl.op = rau_pkg::OP_DIV_NM;
         ST_SNM:  ctl.op = rau_pkg::OP_SAVE_NM;
         ST_DDN:  ctl.op = rau_pkg::OP_DIV_DN;
         ST_SDN:  ctl.op = rau_pkg::OP_SAVE_DN;
         ST_FIN:  ctl.op = out_free ? rau_pkg::OP_FINISH : rau_pkg::OP_NONE;
         ST_FAIL: ctl.op = out_free ? rau_pkg::OP_FAIL : rau_pkg::OP_NONE;
         default: ctl.op = rau_pkg::OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if ((state_ff == ST_FIN || state_ff == ST_FAIL) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               if (stat.invalid) begin
                  state_ff <= ST_FAIL;
               end else if (stat.add_sub) begin
                  state_ff <= ST_GD;
               end else begin
                  state_ff <= ST_PN;
               end
            end
            ST_GD: begin
               ret_ff   <= ST_DQB;
               state_ff <= ST_GRUN;
            end
            ST_GRUN: begin
               if (stat.gcd_done) begin
                  state_ff <= ret_ff;
               end
            end
            ST_DQB: begin
               cnt_ff   <= '0;
               ret_ff   <= ST_SQB;
               state_ff <= ST_DRUN;
            end
            ST_DRUN: begin
               if (cnt_ff == CNT_LAST) begin
                  state_ff <= ret_ff;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            ST_SQB: state_ff <= ST_DQA;
            ST_DQA: begin
               cnt_ff   <= '0;
               ret_ff   <= ST_SQA;
               state_ff <= ST_DRUN;
            end
            ST_SQA:  state_ff <= ST_MTA;
            ST_MTA:  state_ff <= ST_MTB;
            ST_MTB:  state_ff <= ST_MDA;
            ST_MDA:  state_ff <= ST_COMB;
            ST_COMB: state_ff <= ST_GR;
            ST_PN:   state_ff <= ST_PD;
            ST_PD:   state_ff <= ST_GR;
            ST_GR: begin
               ret_ff   <= ST_DNM;
               state_ff <= ST_GRUN;
            end
            ST_DNM: begin
               cnt_ff   <= '0;
               ret_ff   <= ST_SNM;
               state_ff <= ST_DRUN;
            end
            ST_SNM: state_ff <= ST_DDN;
            ST_DDN: begin
               cnt_ff   <= '0;
               ret_ff   <= ST_SDN;
               state_ff <= ST_DRUN;
            end
            ST_SDN: state_ff <= ST_FIN;
            ST_FIN, ST_FAIL: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   a_accept_check: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_CHECK))
      else $error("accepted request did not start processing");

   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_FIN || state_ff == ST_FAIL) && rsp_valid_ff && !rsp_tready)
      |=> (rsp_valid_ff && (state_ff == ST_FIN || state_ff == ST_FAIL)))
      else $error("result issued while output register was occupied");

   a_valid_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FIN || state_ff == ST_FAIL))
      else $error("response raised outside of a finish state");

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRUN && cnt_ff != CNT_LAST) |=> (state_ff == ST_DRUN))
      else $error("divider left before all quotient bits were formed");

endmodule

@@ test/rau_checker.sv @@
// Checker for the rational arithmetic unit: predicts each reduced fraction and compares responses.
`timescale 1ns / 100ps
module rau_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [135:0] req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [71:0]  rsp_tdata,
   output int           fail_count,
   output int           pending_count,
   output int           response_count
);

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] den;
      logic [31:0] num;
   } fraction_result_type;

   fraction_result_type expected_results[$];

   function automatic logic [63:0] gcd_of(logic [63:0] x, logic [63:0] y);
      logic [63:0] t;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   function automatic fraction_result_type reduce_fraction(logic [135:0] d);
      fraction_result_type r;
      logic [1:0]  op;
      logic [63:0] am, bm, ad, bd, gd, ta, tb, nm, dn, g;
      logic        an, bn, tbn, rn;
      logic [31:0] a_raw, b_raw;
      op    = d[1:0];
      a_raw = d[33:2];
      ad    = {32'd0, d[65:34]};
      b_raw = d[97:66];
      bd    = {32'd0, d[129:98]};
      an    = a_raw[31];
      bn    = b_raw[31];
      am    = an ? 64'h1_0000_0000 - a_raw : {32'd0, a_raw};
      bm    = bn ? 64'h1_0000_0000 - b_raw : {32'd0, b_raw};
      r     = '0;
      if (ad == 0 || bd == 0 || (op == rau_pkg::CMD_DIV && bm == 0)) begin
         r.status = rau_pkg::STATUS_INVALID;
         return r;
      end
      if (op == rau_pkg::CMD_ADD || op == rau_pkg::CMD_SUB) begin
         gd  = gcd_of(ad, bd);
         ta  = am * (bd / gd);
         tb  = bm * (ad / gd);
         tbn = (op == rau_pkg::CMD_SUB) ? !bn : bn;
         if (tb == 0) tbn = 1'b0;
         dn = (ad / gd) * bd;
         if (an == tbn) begin
            nm = ta + tb;
            rn = an;
         end else if (ta >= tb) begin
            nm = ta - tb;
            rn = an;
         end else begin
            nm = tb - ta;
            rn = tbn;
         end
      end else if (op == rau_pkg::CMD_MUL) begin
         nm = am * bm;
         dn = ad * bd;
         rn = an ^ bn;
      end else begin
         nm = am * bd;
         dn = ad * bm;
         rn = an ^ bn;
      end
      if (nm == 0) rn = 1'b0;
      g = gcd_of(nm, dn);
      if (g != 0) begin
         nm = nm / g;
         dn = dn / g;
      end
      if (dn > 64'hFFFF_FFFF || (rn ? nm > 64'h8000_0000 : nm > 64'h7FFF_FFFF)) begin
         r.status = rau_pkg::STATUS_OVERFLOW;
         return r;
      end
      r.status = rau_pkg::STATUS_OK;
      r.num    = rn ? 32'(64'd0 - nm) : nm[31:0];
      r.den    = dn[31:0];
      return r;
   endfunction

   always @(posedge clock) begin
      fraction_result_type want, got;
      if (reset) begin
         expected_results.delete();
         fail_count     <= 0;
         response_count <= 0;
      end else begin
         if (req_tvalid && req_tready) expected_results.push_back(reduce_fraction(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[65:0];
            response_count <= response_count + 1;
            if (expected_results.size() == 0) begin
               $error("response with no request outstanding: %h", rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_results.pop_front();
               if (got.num !== want.num)
                  $error("res_num expected %h actual %h", want.num, got.num);
               if (got.den !== want.den)
                  $error("res_den expected %h actual %h", want.den, got.den);
               if (got.status !== want.status)
                  $error("status expected %0d actual %0d", want.status, got.status);
               if (got !== want || rsp_tdata[71:66] !== 6'd0) fail_count <= fail_count + 1;
            end
         end
      end
      pending_count <= expected_results.size();
   end

endmodule

@@ test/testbench.sv @@
// Top of the testbench for the rational arithmetic unit: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module testbench;

   localparam int WATCHDOG_LIMIT = 20000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [135:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [71:0]  rsp_tdata;
   int           fail_count, pending_count, response_count;
   int           send_idle_pct, take_idle_pct;
   int           quiet_cycles = 0;
   int           sent = 0;

   always #2 clock = ~clock;

   rational_arithmetic_unit uut (.*);

   rau_checker checker_inst (.*);

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= !reset && ($urandom_range(99) >= take_idle_pct);
   end

   function automatic logic [31:0] pick_value(bit is_den);
      case ($urandom_range(9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'hFFFF_FFFF;
         3: return is_den ? 32'd0 : 32'd1;
         4, 5: return $urandom;
         default: return is_den ? $urandom_range(1, 60) : $urandom_range(0, 40) - 20;
      endcase
   endfunction

   task automatic send_request(logic [1:0] op, logic [31:0] an, logic [31:0] ad,
                               logic [31:0] bn, logic [31:0] bd);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata  <= {6'd0, bd, bn, ad, an, op};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sent++;
   endtask

   task automatic send_random(int count);
      for (int i = 0; i < count; i++)
         send_request(2'($urandom_range(3)), pick_value(0), pick_value(1),
                      pick_value(0), pick_value(1));
   endtask

   initial begin
      send_idle_pct = 15;
      take_idle_pct = 78;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_request(rau_pkg::CMD_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
      send_request(rau_pkg::CMD_SUB, 32'd1, 32'd2, 32'd1, 32'd2);
      send_request(rau_pkg::CMD_MUL, -32'sd4, 32'd6, 32'd3, 32'd8);
      send_request(rau_pkg::CMD_DIV, 32'd3, 32'd4, -32'sd9, 32'd2);
      send_request(rau_pkg::CMD_ADD, 32'd1, 32'd0, 32'd1, 32'd1);
      send_request(rau_pkg::CMD_MUL, 32'd1, 32'd1, 32'd1, 32'd0);
      send_request(rau_pkg::CMD_DIV, 32'd5, 32'd7, 32'd0, 32'd3);
      send_request(rau_pkg::CMD_MUL, 32'h8000_0000, 32'd1, 32'h8000_0000, 32'd1);
      send_request(rau_pkg::CMD_MUL, 32'h8000_0000, 32'd1, 32'hFFFF_FFFF, 32'd1);
      send_request(rau_pkg::CMD_ADD, 32'h7FFF_FFFF, 32'd1, 32'd1, 32'd1);
      send_request(rau_pkg::CMD_SUB, 32'h8000_0000, 32'd1, 32'd0, 32'd1);
      send_request(rau_pkg::CMD_ADD, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000,
                   32'hFFFF_FFFE);
      send_request(rau_pkg::CMD_DIV, 32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_request(rau_pkg::CMD_MUL, 32'd0, 32'hFFFF_FFFF, 32'h8000_0000, 32'd7);
      send_request(rau_pkg::CMD_DIV, 32'h8000_0000, 32'd1, 32'hFFFF_FFFF, 32'd1);
      send_request(rau_pkg::CMD_SUB, 32'hFFFF_FFFF, 32'd3, 32'hFFFF_FFFF, 32'd3);
      send_random(300);
      send_idle_pct = 78;
      take_idle_pct = 15;
      send_random(300);
      send_idle_pct = 0;
      take_idle_pct = 0;
      send_random(334);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (500) @(posedge clock);
      $display("Sent %0d requests covering all four commands, extreme operands and invalid",
               sent);
      $display("denominators; %0d responses were checked.", response_count);
      if (fail_count == 0 && pending_count == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/rau_pkg.sv
rtl/rau_dp.sv
rtl/rau_ctrl.sv
rtl/rational_arithmetic_unit.sv
test/rau_checker.sv
test/testbench.sv
